>>> rtl/core/uqt_pkg.sv
package uqt_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned KindWidth   = 2;
   localparam int unsigned StatusWidth = 2;

   // Delimiter characters.
   localparam logic [ByteWidth-1:0] CharQuestion = 8'h3F;
   localparam logic [ByteWidth-1:0] CharHash     = 8'h23;
   localparam logic [ByteWidth-1:0] CharEquals   = 8'h3D;
   localparam logic [ByteWidth-1:0] CharAmp      = 8'h26;
   localparam logic [ByteWidth-1:0] CharPercent  = 8'h25;

   // Byte returned when the low digit of an escape is not hex.
   localparam logic [ByteWidth-1:0] ByteBadEscape = 8'hFF;
   localparam logic [NibbleWidth-1:0] NibbleBad   = 4'hF;

   // Field kinds.
   localparam logic [KindWidth-1:0] KindPath   = 2'd0;
   localparam logic [KindWidth-1:0] KindAnchor = 2'd1;
   localparam logic [KindWidth-1:0] KindName   = 2'd2;
   localparam logic [KindWidth-1:0] KindValue  = 2'd3;

   // Status codes.
   localparam logic [StatusWidth-1:0] StatusOk        = 2'd0;
   localparam logic [StatusWidth-1:0] StatusBadHex    = 2'd1;
   localparam logic [StatusWidth-1:0] StatusTruncated = 2'd2;

   typedef enum logic [5:0] {
      MODE_PATH   = 6'b000001,
      MODE_ANCHOR = 6'b000010,
      MODE_NAME   = 6'b000100,
      MODE_VALUE  = 6'b001000,
      MODE_ESC1   = 6'b010000,
      MODE_ESC2   = 6'b100000
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [NibbleWidth-1:0] high_nibble;
      logic                   high_bad;
      logic                   expect_start;
   } parse_state_type;

   localparam parse_state_type StateReset = '{
      mode:         MODE_PATH,
      high_nibble:  '0,
      high_bad:     1'b0,
      expect_start: 1'b0
   };

   typedef struct packed {
      logic [KindWidth-1:0]   field_kind;
      logic                   byte_valid;
      logic [ByteWidth-1:0]   out_byte;
      logic                   param_start;
      logic [StatusWidth-1:0] status;
      logic                   out_last;
   } result_type;

   // Hex digit decode: bit 4 flags a byte that is not a hex digit.
   function automatic logic [NibbleWidth:0] hex_decode(input logic [ByteWidth-1:0] c);
      logic [ByteWidth-1:0] t;
      logic [NibbleWidth:0] r;
      t = '0;
      r = {1'b1, NibbleBad};
      if (c inside {[8'h30:8'h39]}) begin
         t = c - 8'h30;
         r = {1'b0, t[NibbleWidth-1:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
         t = c - 8'h57;
         r = {1'b0, t[NibbleWidth-1:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
         t = c - 8'h37;
         r = {1'b0, t[NibbleWidth-1:0]};
      end
      return r;
   endfunction

endpackage

>>> rtl/core/uqt_req_if.sv
interface uqt_req_if import uqt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] in_byte;
   logic                 in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> rtl/core/uqt_rsp_if.sv
interface uqt_rsp_if import uqt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [KindWidth-1:0]   field_kind;
   logic                   byte_valid;
   logic [ByteWidth-1:0]   out_byte;
   logic                   param_start;
   logic [StatusWidth-1:0] status;
   logic                   out_last;

   modport source (output valid, output field_kind, output byte_valid, output out_byte,
                   output param_start, output status, output out_last, input ready);
   modport sink   (input valid, input field_kind, input byte_valid, input out_byte,
                   input param_start, input status, input out_last, output ready);
endinterface

>>> rtl/core/uri_query_tokenizer_core.sv
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the only limit is the single result register,
// which accepts a new item whenever it is empty or is being drained that cycle.
// Reset: synchronous, active high; the parser returns to path mode with no
// escape pending and the result register empties.
module uri_query_tokenizer_core import uqt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   uqt_req_if.sink   req,
   uqt_rsp_if.source rsp
);

   // The parse state register holds the mode plus the pending escape digit.
   // It is the input-side register: each accepted byte is combined with it
   // in one short block of logic and the outcome lands in the result register.
   parse_state_type state_ff, state_in;
   parse_state_type step_state;
   result_type      step_result;
   result_type      rsp_data;
   logic            rsp_valid;
   logic            accept;
   logic            take;

   // A new item may enter whenever the result register is free or is being
   // taken in this same cycle, so a continuous stream moves one item a cycle.
   assign take       = rsp_valid & rsp.ready;
   assign req.ready  = ~rsp_valid | rsp.ready;
   assign accept     = req.valid & req.ready;

   uqt_step u_step (
      .cur_state (state_ff),
      .in_byte   (req.in_byte),
      .in_last   (req.in_last),
      .nxt_state (step_state),
      .result    (step_result)
   );

   // The state only moves when an item is actually accepted.
   assign state_in = accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
      end else begin
         state_ff <= state_in;
      end
   end

   uqt_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (step_result),
      .take      (take),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // Drive the result channel straight from the result register.
   assign rsp.valid       = rsp_valid;
   assign rsp.field_kind  = rsp_data.field_kind;
   assign rsp.byte_valid  = rsp_data.byte_valid;
   assign rsp.out_byte    = rsp_data.out_byte;
   assign rsp.param_start = rsp_data.param_start;
   assign rsp.status      = rsp_data.status;
   assign rsp.out_last    = rsp_data.out_last;

endmodule

>>> rtl/core/uqt_step.sv
module uqt_step import uqt_pkg::*; (
   input  parse_state_type      cur_state,
   input  logic [ByteWidth-1:0] in_byte,
   input  logic                 in_last,
   output parse_state_type      nxt_state,
   output result_type           result
);

   logic [NibbleWidth:0] hex;

   assign hex = hex_decode(in_byte);

   always_comb begin
      parse_state_type ns;
      result_type      r;
      ns = cur_state;
      r.field_kind  = KindPath;
      r.byte_valid  = 1'b0;
      r.out_byte    = in_byte;
      r.param_start = 1'b0;
      r.status      = StatusOk;
      r.out_last    = in_last;

      case (cur_state.mode)
         MODE_ANCHOR: begin
            r.field_kind = KindAnchor;
            if (in_byte == CharQuestion) begin
               ns.mode         = MODE_NAME;
               ns.expect_start = 1'b1;
            end else begin
               r.byte_valid = 1'b1;
            end
         end
         MODE_NAME: begin
            r.field_kind    = KindName;
            r.param_start   = cur_state.expect_start;
            ns.expect_start = 1'b0;
            if (in_byte == CharEquals) begin
               ns.mode = MODE_VALUE;
            end else begin
               r.byte_valid = 1'b1;
            end
         end
         MODE_VALUE: begin
            r.field_kind = KindValue;
            if (in_byte == CharAmp) begin
               ns.mode         = MODE_NAME;
               ns.expect_start = 1'b1;
            end else if (in_byte == CharPercent) begin
               if (in_last) begin
                  r.status = StatusTruncated;
               end else begin
                  ns.mode = MODE_ESC1;
               end
            end else begin
               r.byte_valid = 1'b1;
            end
         end
         MODE_ESC1: begin
            r.field_kind = KindValue;
            if (in_last) begin
               r.status = StatusTruncated;
            end else begin
               ns.high_bad    = hex[NibbleWidth];
               ns.high_nibble = hex[NibbleWidth-1:0];
               ns.mode        = MODE_ESC2;
            end
         end
         MODE_ESC2: begin
            r.field_kind = KindValue;
            r.byte_valid = 1'b1;
            if (hex[NibbleWidth]) begin
               r.out_byte = ByteBadEscape;
               r.status   = StatusBadHex;
            end else begin
               r.out_byte = {cur_state.high_nibble, hex[NibbleWidth-1:0]};
               if (cur_state.high_bad) begin
                  r.status = StatusBadHex;
               end
            end
            ns.high_bad    = 1'b0;
            ns.high_nibble = '0;
            ns.mode        = MODE_VALUE;
         end
         default: begin
            // Path mode, and any code outside the one-hot set.
            r.field_kind = KindPath;
            if (in_byte == CharQuestion) begin
               ns.mode         = MODE_NAME;
               ns.expect_start = 1'b1;
            end else if (in_byte == CharHash) begin
               ns.mode = MODE_ANCHOR;
            end else begin
               r.byte_valid = 1'b1;
            end
         end
      endcase

      if (in_last) begin
         ns = StateReset;
      end

      nxt_state = ns;
      result    = r;
   end

endmodule

>>> rtl/core/uqt_out_reg.sv
module uqt_out_reg import uqt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_data,
   input  logic       take,
   output logic       out_valid,
   output result_type out_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Loading wins over taking, so a result taken and replaced in the same
   // cycle keeps the register full.
   assign valid_in = load | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> tb/uri_query_tokenizer_core_tb.sv
`timescale 1ns / 100ps

// Testbench for the URI query tokenizer. Every accepted input item is run
// through a local copy of the tokenizer's parse state to work out the result
// item it must produce. Result items are then compared field by field, in
// order, as the block hands them out. Both handshakes idle at random, except
// in one back-to-back phase where neither side ever waits.
module uri_query_tokenizer_core_tb;
   import uqt_pkg::*;

   logic clock;
   logic reset;

   uqt_req_if req_ch ();
   uqt_rsp_if rsp_ch ();

   uri_query_tokenizer_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #6 clock = ~clock;

   // When set, neither the sender nor the receiver inserts any idle cycles.
   bit steady_flow = 1'b0;
   bit failed      = 1'b0;
   int unsigned sent_items = 0;

   // Result items that have been predicted but not yet seen, oldest first.
   result_type expected_tokens[$];

   // Characters of the URI that is about to be sent.
   logic [ByteWidth-1:0] uri_text[$];

   // Local copy of the parse state.
   mode_type               parse_mode_q   = MODE_PATH;
   logic [NibbleWidth-1:0] esc_nibble_q   = '0;
   logic                   esc_bad_q      = 1'b0;
   logic                   param_pending_q = 1'b0;

   // Appends one character to the URI under construction.
   function automatic void add_char(input logic [ByteWidth-1:0] c);
      uri_text.insert(uri_text.size(), c);
   endfunction

   function automatic int unsigned draw_gap();
      return steady_flow ? 0 : $urandom_range(0, 9);
   endfunction

   // Returns 1 and the digit value when c is a hex digit of either case.
   function automatic logic hex_nibble(input logic [ByteWidth-1:0] c,
                                       output logic [NibbleWidth-1:0] v);
      logic [ByteWidth-1:0] folded;
      folded = c | 8'h20;
      v = NibbleBad;
      if (c >= "0" && c <= "9") begin
         v = c[3:0];
         return 1'b1;
      end
      if (folded >= "a" && folded <= "f") begin
         v = c[3:0] + 4'd9;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Works out the result item for one character and advances the parse state.
   function automatic result_type predict_token(input logic [ByteWidth-1:0] c,
                                                input logic is_last);
      result_type             r;
      logic [NibbleWidth-1:0] digit;
      logic                   digit_ok;
      r.field_kind  = KindPath;
      r.byte_valid  = 1'b0;
      r.out_byte    = c;
      r.param_start = 1'b0;
      r.status      = StatusOk;
      r.out_last    = is_last;
      digit_ok = hex_nibble(c, digit);
      case (parse_mode_q)
         MODE_ANCHOR: begin
            // A second '#' is just part of the anchor; only '?' ends it.
            r.field_kind = KindAnchor;
            if (c == CharQuestion) begin
               parse_mode_q    = MODE_NAME;
               param_pending_q = 1'b1;
            end else begin
               r.byte_valid = 1'b1;
            end
         end
         MODE_NAME: begin
            // Names end only at '='; an '&' here is an ordinary name character.
            r.field_kind    = KindName;
            r.param_start   = param_pending_q;
            param_pending_q = 1'b0;
            if (c == CharEquals) parse_mode_q = MODE_VALUE;
            else r.byte_valid = 1'b1;
         end
         MODE_VALUE: begin
            r.field_kind = KindValue;
            if (c == CharAmp) begin
               parse_mode_q    = MODE_NAME;
               param_pending_q = 1'b1;
            end else if (c == CharPercent) begin
               // A '%' with nothing after it cannot start an escape.
               if (is_last) r.status = StatusTruncated;
               else parse_mode_q = MODE_ESC1;
            end else begin
               r.byte_valid = 1'b1;
            end
         end
         MODE_ESC1: begin
            // Any byte counts as the high digit; a bad one becomes nibble F.
            r.field_kind = KindValue;
            if (is_last) begin
               r.status = StatusTruncated;
            end else begin
               esc_bad_q    = !digit_ok;
               esc_nibble_q = digit_ok ? digit : NibbleBad;
               parse_mode_q = MODE_ESC2;
            end
         end
         MODE_ESC2: begin
            r.field_kind = KindValue;
            r.byte_valid = 1'b1;
            if (!digit_ok) begin
               r.out_byte = ByteBadEscape;
               r.status   = StatusBadHex;
            end else begin
               r.out_byte = {esc_nibble_q, digit};
               if (esc_bad_q) r.status = StatusBadHex;
            end
            esc_bad_q    = 1'b0;
            esc_nibble_q = '0;
            parse_mode_q = MODE_VALUE;
         end
         default: begin
            r.field_kind = KindPath;
            if (c == CharQuestion) begin
               parse_mode_q    = MODE_NAME;
               param_pending_q = 1'b1;
            end else if (c == CharHash) begin
               parse_mode_q = MODE_ANCHOR;
            end else begin
               r.byte_valid = 1'b1;
            end
         end
      endcase
      // The end of a URI puts the parser back into its reset state.
      if (is_last) begin
         parse_mode_q    = MODE_PATH;
         esc_nibble_q    = '0;
         esc_bad_q       = 1'b0;
         param_pending_q = 1'b0;
      end
      return r;
   endfunction

   // Sends one character. Valid is only lowered when a gap is drawn, so a
   // back-to-back item never sees valid dropped and raised in one step.
   task automatic send_char(input logic [ByteWidth-1:0] c, input logic is_last);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= c;
      req_ch.in_last <= is_last;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      expected_tokens.insert(expected_tokens.size(), predict_token(c, is_last));
      sent_items++;
   endtask

   task automatic send_uri();
      foreach (uri_text[i]) send_char(uri_text[i], i == uri_text.size() - 1);
   endtask

   // Mostly URI-safe text, now and then any byte at all.
   function automatic logic [ByteWidth-1:0] plain_char();
      string letters;
      letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~/+";
      if ($urandom_range(0, 9) == 0) return ByteWidth'($urandom_range(0, 255));
      return letters[$urandom_range(0, letters.len() - 1)];
   endfunction

   // Mostly a hex digit of either case, sometimes a random byte.
   function automatic logic [ByteWidth-1:0] hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      if ($urandom_range(0, 5) == 0) return ByteWidth'($urandom_range(0, 255));
      return digits[$urandom_range(0, digits.len() - 1)];
   endfunction

   // Builds a URI into uri_text. Most are well formed, path then optional
   // anchor then optional query, with random content; the rest are delimiter-heavy
   // noise, and some well-formed ones end in a cut-off escape.
   task automatic compose_uri();
      string       delims;
      int unsigned n;
      int unsigned params;
      delims = "?#=&%";
      uri_text.delete();
      if ($urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 12);
         repeat (n) begin
            if ($urandom_range(0, 1) == 0)
               add_char(delims[$urandom_range(0, delims.len() - 1)]);
            else
               add_char(ByteWidth'($urandom_range(0, 255)));
         end
         return;
      end
      n = $urandom_range(0, 6);
      repeat (n) add_char(plain_char());
      if ($urandom_range(0, 3) == 0) begin
         add_char(CharHash);
         n = $urandom_range(0, 4);
         repeat (n) begin
            if ($urandom_range(0, 5) == 0) add_char(CharHash);
            else add_char(plain_char());
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         add_char(CharQuestion);
         params = $urandom_range(1, 4);
         for (int p = 0; p < params; p++) begin
            if (p != 0) add_char(CharAmp);
            n = $urandom_range(0, 4);
            repeat (n) begin
               if ($urandom_range(0, 5) == 0) add_char(CharAmp);
               else add_char(plain_char());
            end
            add_char(CharEquals);
            n = $urandom_range(0, 4);
            repeat (n) begin
               if ($urandom_range(0, 2) == 0) begin
                  add_char(CharPercent);
                  add_char(hex_char());
                  add_char(hex_char());
               end else begin
                  add_char(plain_char());
               end
            end
         end
      end
      // Sometimes leave an escape unfinished at the very end.
      if ($urandom_range(0, 7) == 0) begin
         add_char(CharPercent);
         if ($urandom_range(0, 1) == 0) add_char(hex_char());
      end
      if (uri_text.size() == 0) add_char(plain_char());
   endtask

   // Field extremes, every field kind, hash inside the anchor, ampersand in a
   // name, good and bad escapes, and escapes cut off at '%' and at the high digit.
   task automatic test_directed();
      uri_text = '{8'h00, CharHash, CharHash, "x", CharQuestion, CharAmp, CharEquals,
                   CharPercent, "4", "a", CharPercent, "z", "9", CharPercent, "0", "G",
                   CharAmp, 8'hFF, CharEquals, "F", CharPercent};
      send_uri();
      uri_text = '{CharQuestion, CharEquals, CharPercent, "A"};
      send_uri();
   endtask

   // A stretch with no idling on either side.
   task automatic test_back_to_back();
      steady_flow = 1'b1;
      while (sent_items < 175) begin
         compose_uri();
         send_uri();
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_random_uris();
      while (sent_items < 950) begin
         compose_uri();
         send_uri();
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // Result side: draws a stall before each item, then checks what arrives.
   initial begin
      int unsigned stall;
      result_type  got;
      result_type  want;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         got = {rsp_ch.field_kind, rsp_ch.byte_valid, rsp_ch.out_byte,
                rsp_ch.param_start, rsp_ch.status, rsp_ch.out_last};
         if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected result item, expected none, got %h", $time, got);
            failed = 1'b1;
         end else begin
            want = expected_tokens.pop_front();
            check_field("field_kind", 32'(want.field_kind), 32'(got.field_kind));
            check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
            check_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
            check_field("param_start", 32'(want.param_start), 32'(got.param_start));
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("out_last", 32'(want.out_last), 32'(got.out_last));
         end
      end
   end

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = '0;
      req_ch.in_last = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_back_to_back();
      test_random_uris();
      req_ch.valid <= 1'b0;

      // Drain, then keep watching briefly for anything stray to show up.
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (!failed) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // A timeout far beyond the slowest correct run.
   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/uqt_pkg.sv
rtl/core/uqt_req_if.sv
rtl/core/uqt_rsp_if.sv
rtl/core/uqt_step.sv
rtl/core/uqt_out_reg.sv
rtl/core/uri_query_tokenizer_core.sv
tb/uri_query_tokenizer_core_tb.sv
